FILE: src/rav_pkg.sv
// Shared constants and types for the rotated box volume block.
package rav_pkg;

  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_ROWS  = 3;
  localparam int VOL_W     = 53;

  typedef logic [CFG_W-1:0] cfg_row_t;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 2'd2;

  localparam cfg_row_t ROW_X_RESET = 48'h4000_0000_0000;
  localparam cfg_row_t ROW_Y_RESET = 48'h0000_4000_0000;
  localparam cfg_row_t ROW_Z_RESET = 48'h0000_0000_4000;

endpackage

FILE: src/rav_fifo.sv
// Short transaction queue between the projection front and the volume back.
module rav_fifo #(
  parameter int WIDTH = 55,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign ready   = (count != CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && ready;
  assign do_pop  = pop && valid;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/rav_front.sv
// Front end: accepts points and projects them onto the three rotation rows.
module rav_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic                          last_point,
  input  rav_pkg::cfg_row_t             rows [rav_pkg::NUM_ROWS],
  output logic                          q_push,
  input  logic                          q_ready,
  output logic [3*(COORD_WIDTH+2):0]    q_data
);
  import rav_pkg::*;

  localparam int PRW  = COORD_WIDTH + COEF_W;
  localparam int SUMW = PRW + 2;
  localparam int SHW  = SUMW - FRAC_BITS;
  localparam int PW   = COORD_WIDTH + 2;
  localparam int LIM  = 3 << (COORD_WIDTH - 1);

  logic signed [PRW-1:0] prod [NUM_ROWS][3];
  logic                  last1;
  logic                  v1;
  logic signed [PW-1:0]  proj [NUM_ROWS];
  logic                  last2;
  logic                  v2;
  logic signed [PW-1:0]  proj_next [NUM_ROWS];
  logic                  en1;
  logic                  en2;
  logic                  accept;

  assign en2      = !v2 || q_ready;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;
  assign q_push   = v2;
  assign q_data   = {last2, proj[2], proj[1], proj[0]};

  always_comb begin
    logic signed [SUMW-1:0] sum;
    logic signed [SHW-1:0]  sh;
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum = SUMW'(prod[r][0]) + SUMW'(prod[r][1]) + SUMW'(prod[r][2]);
      sh  = $signed(sum[SUMW-1:FRAC_BITS]);
      if (sh > LIM) begin
        proj_next[r] = PW'(LIM);
      end else if (sh < -LIM) begin
        proj_next[r] = PW'(-LIM);
      end else begin
        proj_next[r] = PW'(sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        prod[r][0] <= $signed(rows[r][47:32]) * point_x;
        prod[r][1] <= $signed(rows[r][31:16]) * point_y;
        prod[r][2] <= $signed(rows[r][15:0]) * point_z;
      end
      last1 <= last_point;
    end
    if (en2) begin
      proj  <= proj_next;
      last2 <= last1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

endmodule

FILE: src/rav_back.sv
// Back end: tracks per-axis extremes and multiplies the extents into a volume.
module rav_back #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  logic [3*(COORD_WIDTH+2):0] q_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rav_pkg::VOL_W-1:0]  box_volume
);
  import rav_pkg::*;

  localparam int PW = COORD_WIDTH + 2;
  localparam int EW = PW;
  localparam int SW = (3 * EW > VOL_W) ? 3 * EW : VOL_W;

  logic signed [PW-1:0] axis_minimum [NUM_ROWS];
  logic signed [PW-1:0] axis_maximum [NUM_ROWS];
  logic                 set_open;
  logic signed [PW-1:0] min_next [NUM_ROWS];
  logic signed [PW-1:0] max_next [NUM_ROWS];
  logic signed [PW:0]   span [NUM_ROWS];
  logic                 q_last;

  logic [EW-1:0]   ext [NUM_ROWS];
  logic            v1;
  logic [2*EW-1:0] prod12;
  logic [EW-1:0]   ext3;
  logic            v2;
  logic [2*EW-1:0] part_lo;
  logic [2*EW-1:0] part_hi;
  logic            v3;
  logic [SW-1:0]   vol_sum;
  logic            en_out;
  logic            en3;
  logic            en2;
  logic            en1;

  assign q_last  = q_data[3*PW];
  assign en_out  = !out_valid || !out_stall;
  assign en3     = !v3 || en_out;
  assign en2     = !v2 || en3;
  assign en1     = !v1 || en2;
  assign q_pop   = q_valid && (!q_last || en1);
  assign vol_sum = SW'(part_lo) + (SW'(part_hi) << EW);

  always_comb begin
    logic signed [PW-1:0] p;
    for (int i = 0; i < NUM_ROWS; i++) begin
      p = $signed(q_data[i*PW +: PW]);
      min_next[i] = (!set_open || p < axis_minimum[i]) ? p : axis_minimum[i];
      max_next[i] = (!set_open || p > axis_maximum[i]) ? p : axis_maximum[i];
      span[i]     = (PW+1)'(max_next[i]) - (PW+1)'(min_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      axis_minimum <= min_next;
      axis_maximum <= max_next;
    end
    if (en1 && q_pop && q_last) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        ext[i] <= span[i][EW-1:0];
      end
    end
    if (en2) begin
      prod12 <= ext[0] * ext[1];
      ext3   <= ext[2];
    end
    if (en3) begin
      part_lo <= prod12[EW-1:0] * ext3;
      part_hi <= prod12[2*EW-1:EW] * ext3;
    end
    if (en_out) begin
      box_volume <= vol_sum[VOL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_open  <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        set_open <= !q_last;
      end
      if (en1) begin
        v1 <= q_pop && q_last;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en_out) begin
        out_valid <= v3;
      end
    end
  end

endmodule

FILE: src/rotated_aabb_volume.sv
// Top level of the rotated box volume block: rotation rows, front, queue, back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   in       | in_valid / in_stall    | point_x, point_y, point_z, last_point
//   out      | out_valid / out_stall  | box_volume
//   cfg      | cfg_write              | cfg_index, cfg_data
//
// One point per cycle sustained while in_stall is low; the nine coefficient
// products and the min/max update are registered. out_valid rises after the last
// point passes projection, queue, extreme update, 2 multiply stages and output.
// Reset clears all valid flags and reloads the identity rotation.
// Stalled output backs up volume stages, the queue at a last point, then in_stall.
module rotated_aabb_volume #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rav_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rav_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     point_x,
  input  logic signed [COORD_WIDTH-1:0]     point_y,
  input  logic signed [COORD_WIDTH-1:0]     point_z,
  input  logic                              last_point,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rav_pkg::VOL_W-1:0]         box_volume
);
  import rav_pkg::*;

  localparam int QW = 3 * (COORD_WIDTH + 2) + 1;

  cfg_row_t        rows [NUM_ROWS];
  logic            q_push;
  logic            q_ready;
  logic [QW-1:0]   q_in;
  logic            q_valid;
  logic            q_pop;
  logic [QW-1:0]   q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= ROW_X_RESET;
      rows[1] <= ROW_Y_RESET;
      rows[2] <= ROW_Z_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_X: rows[0] <= cfg_data;
        REG_ROW_Y: rows[1] <= cfg_data;
        REG_ROW_Z: rows[2] <= cfg_data;
        default:   ;
      endcase
    end
  end

  rav_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .last_point (last_point),
    .rows       (rows),
    .q_push     (q_push),
    .q_ready    (q_ready),
    .q_data     (q_in)
  );

  rav_fifo #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  rav_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_head),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .box_volume (box_volume)
  );

endmodule
